@@ src/fwmrd_pkg.sv @@
package fwmrd_pkg;

    // Request codes carried by req_type.
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_SET     = 2'd1,
        REQ_VECTOR  = 2'd2,
        REQ_PATTERN = 2'd3
    } req_t;

    // Motion patterns; the remaining codes leave the setpoints alone.
    localparam logic [2:0] PAT_STOP     = 3'd0;
    localparam logic [2:0] PAT_FORWARD  = 3'd1;
    localparam logic [2:0] PAT_TURN     = 3'd2;
    localparam logic [2:0] PAT_DIAGONAL = 3'd3;
    localparam logic [2:0] PAT_PULLOVER = 3'd4;

    // Drive direction codes.
    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    // Configuration register indices.
    localparam logic [1:0] CFG_RAMP_STEP   = 2'd0;
    localparam logic [1:0] CFG_SPEED_LIMIT = 2'd1;
    localparam logic [1:0] CFG_ARM_FACTOR  = 2'd2;

    localparam logic [7:0] RAMP_STEP_RESET   = 8'd5;
    localparam logic [7:0] SPEED_LIMIT_RESET = 8'd100;
    localparam logic [3:0] ARM_FACTOR_RESET  = 4'd1;

    localparam int NUM_CH = 4;

    // Unclamped setpoint; wide enough for Y + 15 * W.
    typedef logic signed [14:0] raw_t;

    typedef struct packed {
        logic             tick;
        logic [NUM_CH-1:0] load;
        raw_t [NUM_CH-1:0] raw;
    } mix_t;

    typedef struct packed {
        logic tick;
        logic load;
        raw_t raw;
    } lane_ctrl_t;

    typedef struct packed {
        logic [7:0] duty;
        logic [1:0] dir;
        logic       changed;
    } lane_stat_t;

    typedef struct packed {
        logic [NUM_CH-1:0][7:0] duty;
        logic [NUM_CH-1:0][1:0] dir;
        logic [NUM_CH-1:0]      mask;
    } result_t;

endpackage

@@ src/four_wheel_mix_ramp_drive_top.sv @@
// Four-channel omni-wheel drive mixer with slew-rate limited speed ramps. Each
// input transaction is a tick or a command (set one channel, vector move or
// pattern move); every accepted transaction yields exactly one result giving
// the duty, direction and changed-channel mask of the present drive state.
// Setpoints are clamped to +/-speed_limit when written. The four channels are
// updated in parallel in the cycle the transaction is accepted, so one
// transaction is taken per clock while in_ready is high; the result is
// registered into a two-entry output queue, and in_ready drops only when
// both entries are held. Configuration writes are taken at once (cfg_ready
// is always high) and should be made while the block is idle.
module four_wheel_mix_ramp_drive_top
    import fwmrd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [1:0]  cfg_index,
    input  logic        [7:0]  cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic        [1:0]  req_type,
    input  logic        [1:0]  motor_index,
    input  logic signed [10:0] speed_value,
    input  logic        [2:0]  pattern,
    input  logic signed [9:0]  x_value,
    input  logic signed [9:0]  y_value,
    input  logic signed [9:0]  w_value,

    output logic               out_valid,
    input  logic               out_ready,
    output logic        [7:0]  duty_a,
    output logic        [7:0]  duty_b,
    output logic        [7:0]  duty_c,
    output logic        [7:0]  duty_d,
    output logic        [1:0]  dir_a,
    output logic        [1:0]  dir_b,
    output logic        [1:0]  dir_c,
    output logic        [1:0]  dir_d,
    output logic        [3:0]  changed_mask
);

    logic [7:0] ramp_step_reg;
    logic [7:0] speed_limit_reg;
    logic [3:0] arm_factor_reg;

    mix_t       mix;
    lane_stat_t stat [NUM_CH];
    result_t    item;

    logic       push;
    logic       pop;
    logic       v0_reg;
    logic       v0_next;
    logic       v1_reg;
    logic       v1_next;
    result_t    q0_reg;
    result_t    q0_next;
    result_t    q1_reg;
    result_t    q1_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_step_reg   <= RAMP_STEP_RESET;
            speed_limit_reg <= SPEED_LIMIT_RESET;
            arm_factor_reg  <= ARM_FACTOR_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RAMP_STEP:   ramp_step_reg   <= cfg_data;
                CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
                CFG_ARM_FACTOR:  arm_factor_reg  <= cfg_data[3:0];
                default:         ramp_step_reg   <= ramp_step_reg;
            endcase
        end
    end

    assign in_ready = !v1_reg;
    assign push     = in_valid && in_ready;
    assign pop      = v0_reg && out_ready;

    fwmrd_mix u_mix (
        .req_type    (req_type),
        .motor_index (motor_index),
        .speed_value (speed_value),
        .pattern     (pattern),
        .x_value     (x_value),
        .y_value     (y_value),
        .w_value     (w_value),
        .arm_factor  (arm_factor_reg),
        .mix         (mix)
    );

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        lane_ctrl_t ctrl;

        assign ctrl.tick = mix.tick;
        assign ctrl.load = mix.load[ch];
        assign ctrl.raw  = mix.raw[ch];

        fwmrd_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .step_en     (push),
            .ctrl        (ctrl),
            .ramp_step   (ramp_step_reg),
            .speed_limit (speed_limit_reg),
            .stat        (stat[ch])
        );

        assign item.duty[ch] = stat[ch].duty;
        assign item.dir[ch]  = stat[ch].dir;
        assign item.mask[ch] = stat[ch].changed;
    end

    // Two-entry result queue: the head drives the outputs.
    always_comb
    begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        q0_next = q0_reg;
        q1_next = q1_reg;
        if (pop)
        begin
            q0_next = q1_reg;
            v0_next = v1_reg;
            v1_next = 1'b0;
        end
        if (push)
        begin
            if (!v0_next)
            begin
                q0_next = item;
                v0_next = 1'b1;
            end
            else
            begin
                q1_next = item;
                v1_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign out_valid    = v0_reg;
    assign duty_a       = q0_reg.duty[0];
    assign duty_b       = q0_reg.duty[1];
    assign duty_c       = q0_reg.duty[2];
    assign duty_d       = q0_reg.duty[3];
    assign dir_a        = q0_reg.dir[0];
    assign dir_b        = q0_reg.dir[1];
    assign dir_c        = q0_reg.dir[2];
    assign dir_d        = q0_reg.dir[3];
    assign changed_mask = q0_reg.mask;

`ifndef SYNTHESIS
    // The second queue entry is only ever occupied behind the first.
    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> v0_reg)
        else $error("result queue tail held without a head");

    // A full queue that drains without refill leaves exactly one result.
    a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && pop && !push) |=> (v0_reg && !v1_reg))
        else $error("result lost or duplicated while draining");

    // An accepted transaction into an empty queue is offered next cycle.
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !v0_reg) |=> out_valid)
        else $error("accepted transaction produced no result");

    // Channel A, when reported as off, must show zero duty.
    a_dir_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dir_a == DIR_OFF) |-> (duty_a == 8'd0))
        else $error("channel A off with non-zero duty");
`endif

endmodule

@@ src/fwmrd_mix.sv @@
module fwmrd_mix
    import fwmrd_pkg::*;
(
    input  logic        [1:0]  req_type,
    input  logic        [1:0]  motor_index,
    input  logic signed [10:0] speed_value,
    input  logic        [2:0]  pattern,
    input  logic signed [9:0]  x_value,
    input  logic signed [9:0]  y_value,
    input  logic signed [9:0]  w_value,
    input  logic        [3:0]  arm_factor,
    output mix_t               mix
);

    raw_t x_s;
    raw_t y_s;
    raw_t w_s;
    raw_t arm_s;
    raw_t rot;
    raw_t sv_s;

    assign x_s   = {{5{x_value[9]}}, x_value};
    assign y_s   = {{5{y_value[9]}}, y_value};
    assign w_s   = {{5{w_value[9]}}, w_value};
    assign sv_s  = {{4{speed_value[10]}}, speed_value};
    assign arm_s = {11'd0, arm_factor};
    // The product of a 4-bit factor and a 10-bit term always fits in 15 bits.
    assign rot   = arm_s * w_s;

    always_comb
    begin
        mix.tick = 1'b0;
        mix.load = '0;
        mix.raw  = '{default: '0};
        case (req_t'(req_type))
            REQ_TICK:
            begin
                mix.tick = 1'b1;
            end
            REQ_SET:
            begin
                mix.load[motor_index] = 1'b1;
                mix.raw = '{default: sv_s};
            end
            REQ_VECTOR:
            begin
                mix.load   = '1;
                mix.raw[0] = y_s + rot;
                mix.raw[1] = rot - x_s;
                mix.raw[2] = rot - y_s;
                mix.raw[3] = x_s + rot;
            end
            REQ_PATTERN:
            begin
                case (pattern)
                    PAT_STOP:
                    begin
                        mix.load = '1;
                    end
                    PAT_FORWARD:
                    begin
                        mix.load   = '1;
                        mix.raw[0] = x_s - y_s;
                        mix.raw[1] = x_s - y_s;
                        mix.raw[2] = x_s + y_s;
                        mix.raw[3] = x_s + y_s;
                    end
                    PAT_TURN:
                    begin
                        mix.load   = '1;
                        mix.raw[0] = x_s - y_s;
                        mix.raw[1] = x_s + y_s;
                        mix.raw[2] = x_s - y_s;
                        mix.raw[3] = x_s + y_s;
                    end
                    PAT_DIAGONAL:
                    begin
                        mix.load   = '1;
                        mix.raw[0] = x_s;
                        mix.raw[2] = x_s;
                    end
                    PAT_PULLOVER:
                    begin
                        mix.load   = '1;
                        mix.raw[0] = -x_s;
                        mix.raw[1] = x_s;
                        mix.raw[2] = -x_s;
                        mix.raw[3] = x_s;
                    end
                    default:
                    begin
                        mix.load = '0;
                    end
                endcase
            end
            default:
            begin
                mix.tick = 1'b0;
            end
        endcase
    end

endmodule

@@ src/fwmrd_lane.sv @@
module fwmrd_lane
    import fwmrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  lane_ctrl_t ctrl,
    input  logic [7:0] ramp_step,
    input  logic [7:0] speed_limit,
    output lane_stat_t stat
);

    logic signed [8:0] target_reg;
    logic signed [8:0] target_next;
    logic signed [8:0] present_reg;
    logic signed [8:0] present_next;
    raw_t              lim_pos;
    raw_t              lim_neg;
    raw_t              raw_s;
    logic signed [9:0] cur_w;
    logic signed [9:0] tgt_w;
    logic signed [9:0] step_w;
    logic signed [9:0] up_w;
    logic signed [9:0] dn_w;
    logic signed [8:0] mag;

    assign lim_pos = {7'd0, speed_limit};
    assign lim_neg = -lim_pos;
    assign raw_s   = ctrl.raw;
    assign cur_w   = {present_reg[8], present_reg};
    assign tgt_w   = {target_reg[8], target_reg};
    assign step_w  = {2'b00, ramp_step};
    assign up_w    = cur_w + step_w;
    assign dn_w    = cur_w - step_w;

    always_comb
    begin
        target_next = target_reg;
        if (ctrl.load)
        begin
            if (raw_s > lim_pos)
            begin
                target_next = lim_pos[8:0];
            end
            else if (raw_s < lim_neg)
            begin
                target_next = lim_neg[8:0];
            end
            else
            begin
                target_next = raw_s[8:0];
            end
        end
    end

    // On a tick, move toward the setpoint by one ramp step, stopping exactly on it.
    always_comb
    begin
        present_next = present_reg;
        if (ctrl.tick)
        begin
            if (tgt_w > cur_w)
            begin
                present_next = (up_w > tgt_w) ? target_reg : up_w[8:0];
            end
            else if (tgt_w < cur_w)
            begin
                present_next = (dn_w < tgt_w) ? target_reg : dn_w[8:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= '0;
            present_reg <= '0;
        end
        else if (step_en)
        begin
            target_reg  <= target_next;
            present_reg <= present_next;
        end
    end

    assign mag          = present_next[8] ? -present_next : present_next;
    assign stat.duty    = mag[7:0];
    assign stat.dir     = present_next[8] ? DIR_REV :
                          ((present_next != '0) ? DIR_FWD : DIR_OFF);
    assign stat.changed = (present_next != present_reg);

endmodule
